// ===== design/dltq_pkg.sv =====
// Package for the delta-list timer queue: constants, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;
   localparam int SLOTS_DEFAULT = 16;
   localparam logic [30:0] TMO_MAX = 31'h7FFF_FFFF;

   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_ABORT    = 2'd1;
   localparam logic [1:0] OP_ANNOUNCE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_ACTIVE   = 2'd2;

   typedef struct packed {
      logic load;       // capture request fields
      logic clr_d;      // start scan: d = ticks+1+hw, pos = len
      logic add_step;   // compare one entry during add
      logic add_write;  // start insert shift from the end of the list
      logic shift_up;   // one step of order shift for insert; last step writes entry at pos
      logic find_step;  // abort search step
      logic unlink;     // fold delta of found entry into successor
      logic shift_down; // one step of order shift for removal
      logic ann_pop;    // pop head during announce
      logic ann_fin;    // finish announce
      logic set_reprog;
      logic set_inact;
      logic set_act;
   } cmd_type;

   typedef struct packed {
      logic       op_add;
      logic       op_abort;
      logic       op_ann;
      logic       ignore;     // add ignored
      logic       active;     // id is active
      logic       scan_done;  // add scan finished (pos found)
      logic       shift_done; // shift reached pos
      logic       found;      // abort located
      logic       head_due;   // announce head expired
      logic       pos_head;   // insert position is the head
   } sts_type;
endpackage
`default_nettype wire

// ===== design/dltq_datapath.sv =====
// Datapath of the delta-list timer queue: delta store, order store, counters.
// Uses dltq_pkg; driven by dltq_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module dltq_datapath #(
   parameter int SLOTS = dltq_pkg::SLOTS_DEFAULT,
   localparam int IW = $clog2(SLOTS),
   localparam int LW = $clog2(SLOTS + 1)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  dltq_pkg::cmd_type   cmd,
   output dltq_pkg::sts_type   sts,
   input  wire [1:0]           req_op,
   input  wire [3:0]           req_id,
   input  wire [30:0]          req_ticks,
   input  wire                 req_forever,
   input  wire [30:0]          req_hw,
   output logic [3:0]          head_id,
   output logic [1:0]          status,
   output logic                reprogram,
   output logic [30:0]         hw_tmo,
   output logic [63:0]         pop_tick,
   output logic [63:0]         tick_ff
);
   logic [31:0]   delta_ff [SLOTS];
   logic [IW-1:0] order_ff [SLOTS];
   logic [SLOTS-1:0] active_ff;
   logic [LW-1:0] len_ff;
   logic [1:0]    op_ff;
   logic [IW-1:0] id_ff;
   logic          id_ok_ff;
   logic          forever_ff;
   logic [30:0]   hw_ff;
   logic [31:0]   d_ff;       // remaining delta (add) or remaining ticks (announce)
   logic [LW-1:0] i_ff;       // scan position
   logic [LW-1:0] pos_ff;
   logic          done_ff;
   logic [1:0]    status_ff;
   logic          reprog_ff;
   logic [63:0]   tick_in;

   logic [IW-1:0] cur_id;
   logic [31:0]   cur_delta;
   logic [IW-1:0] head;
   logic [32:0]   diff;

   assign cur_id    = order_ff[i_ff[IW-1:0]];
   assign cur_delta = delta_ff[cur_id];
   assign head      = order_ff[0];

   always_comb begin
      sts.op_add     = (op_ff == dltq_pkg::OP_ADD);
      sts.op_abort   = (op_ff == dltq_pkg::OP_ABORT);
      sts.op_ann     = (op_ff == dltq_pkg::OP_ANNOUNCE);
      sts.ignore     = forever_ff | !id_ok_ff;
      sts.active     = id_ok_ff & active_ff[id_ff];
      sts.scan_done  = done_ff | (i_ff >= len_ff);
      sts.shift_done = (i_ff <= pos_ff);
      sts.found      = (i_ff < len_ff) && (cur_id == id_ff);
      sts.head_due   = (len_ff != '0) && (delta_ff[head] <= d_ff);
      sts.pos_head   = (pos_ff == '0);
   end

   assign diff = {1'b0, delta_ff[head]} - {2'b0, hw_ff};
   always_comb begin
      if (len_ff == '0) hw_tmo = dltq_pkg::TMO_MAX;
      else if (diff[32]) hw_tmo = '0;
      else if (diff[31]) hw_tmo = dltq_pkg::TMO_MAX;
      else hw_tmo = diff[30:0];
   end
   assign head_id   = 4'(head);
   assign status    = status_ff;
   assign reprogram = reprog_ff;
   // head expiry tick while no finish is under way
   assign tick_in   = tick_ff + 64'(cmd.ann_fin ? d_ff : delta_ff[head]);
   assign pop_tick  = tick_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_op;
         id_ff      <= IW'(req_id);
         id_ok_ff   <= (32'(req_id) < SLOTS);
         forever_ff <= req_forever;
         hw_ff      <= req_hw;
         d_ff       <= {1'b0, req_ticks};
         i_ff       <= '0;
         done_ff    <= 1'b0;
      end
      if (cmd.clr_d) begin
         d_ff    <= 32'({1'b0, d_ff[30:0]} + 32'd1 + {1'b0, hw_ff});
         pos_ff  <= len_ff;
      end
      if (cmd.add_step) begin
         if (cur_delta > d_ff) begin
            delta_ff[cur_id] <= cur_delta - d_ff;
            pos_ff  <= i_ff;
            done_ff <= 1'b1;
         end else begin
            d_ff <= d_ff - cur_delta;
            i_ff <= i_ff + 1'b1;
         end
      end
      if (cmd.add_write) begin
         i_ff <= len_ff;
      end
      if (cmd.shift_up) begin
         if (i_ff > pos_ff) begin
            order_ff[i_ff[IW-1:0]] <= order_ff[i_ff[IW-1:0] - 1'b1];
            i_ff <= i_ff - 1'b1;
         end else begin
            order_ff[pos_ff[IW-1:0]] <= id_ff;
            delta_ff[id_ff] <= d_ff;
            len_ff <= len_ff + 1'b1;
         end
      end
      if (cmd.find_step) i_ff <= i_ff + 1'b1;
      if (cmd.unlink) begin
         if (i_ff + 1'b1 < len_ff)
            delta_ff[order_ff[i_ff[IW-1:0] + 1'b1]] <=
               delta_ff[order_ff[i_ff[IW-1:0] + 1'b1]] + cur_delta;
      end
      if (cmd.shift_down) begin
         if (i_ff + 1'b1 < len_ff) begin
            order_ff[i_ff[IW-1:0]] <= order_ff[i_ff[IW-1:0] + 1'b1];
            i_ff <= i_ff + 1'b1;
         end else begin
            len_ff <= len_ff - 1'b1;
         end
      end
      if (cmd.ann_pop) begin
         d_ff <= d_ff - delta_ff[head];
         delta_ff[head] <= '0;
         i_ff <= '0;
      end
      if (cmd.ann_fin && len_ff != '0) delta_ff[head] <= delta_ff[head] - d_ff;
      if (cmd.set_inact) status_ff <= dltq_pkg::ST_INACTIVE;
      if (cmd.set_act)   status_ff <= dltq_pkg::ST_ACTIVE;
      if (cmd.set_reprog) reprog_ff <= 1'b1;
      if (cmd.load) begin
         status_ff <= dltq_pkg::ST_OK;
         reprog_ff <= 1'b0;
      end
      if (reset) begin
         len_ff    <= '0;
         active_ff <= '0;
         tick_ff   <= '0;
      end else begin
         if (cmd.shift_up && !(i_ff > pos_ff)) active_ff[id_ff] <= 1'b1;
         if (cmd.unlink) active_ff[cur_id] <= 1'b0;
         if (cmd.ann_pop) active_ff[head] <= 1'b0;
         if (cmd.ann_pop || cmd.ann_fin) tick_ff <= tick_in;
      end
   end

`ifndef SYNTHESIS
   a_len: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= SLOTS) else $error("queue length overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      32'($countones(active_ff)) == 32'(len_ff) || cmd.shift_up || cmd.shift_down
      || $past(cmd.shift_up) || $past(cmd.shift_down))
      else $error("active count mismatch");
   a_tick: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ann_pop || cmd.ann_fin) && !$past(reset) |=> tick_ff == $past(tick_ff) || $past(reset))
      else $error("tick changed outside announce");
`endif
endmodule
`default_nettype wire

// ===== design/dltq_ctrl.sv =====
// Controller state machine for the delta-list timer queue.
// Uses dltq_pkg; drives dltq_datapath and the stream handshakes.
`timescale 1ns / 1ps
`default_nettype none
module dltq_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic               rsp_kind,
   output dltq_pkg::cmd_type  cmd,
   input  dltq_pkg::sts_type  sts
);
   localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_ADDI = 4'd2,
      S_SCAN = 4'd3, S_INS = 4'd4, S_FIND = 4'd5, S_UNL = 4'd6, S_SHD = 4'd7,
      S_ANN = 4'd8, S_EXP = 4'd9, S_POP = 4'd10, S_SUM = 4'd11,
      S_FIN = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_kind = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.op_add) begin
               if (sts.ignore) state_in = S_SUM;
               else if (sts.active) begin
                  cmd.set_act = 1'b1;
                  state_in = S_SUM;
               end else begin
                  cmd.clr_d = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (sts.op_abort) begin
               if (!sts.active) begin
                  cmd.set_inact = 1'b1;
                  state_in = S_SUM;
               end else state_in = S_FIND;
            end else if (sts.op_ann) begin
               cmd.set_reprog = 1'b1;
               state_in = S_ANN;
            end else state_in = S_SUM;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               cmd.add_write = 1'b1;
               state_in = S_INS;
            end else cmd.add_step = 1'b1;
         end
         S_INS: begin
            cmd.shift_up = 1'b1;
            if (sts.shift_done) state_in = S_ADDI;
         end
         S_ADDI: begin
            if (sts.pos_head) cmd.set_reprog = 1'b1;
            state_in = S_SUM;
         end
         S_FIND: begin
            if (sts.found) begin
               cmd.unlink = 1'b1;
               state_in = S_SHD;
            end else cmd.find_step = 1'b1;
         end
         S_SHD: begin
            if (sts.scan_done) state_in = S_SUM;
            else cmd.shift_down = 1'b1;
         end
         S_ANN: begin
            if (sts.head_due) state_in = S_EXP;
            else state_in = S_FIN;
         end
         S_EXP: begin
            rsp_tvalid = 1'b1;
            rsp_kind = 1'b0;
            if (rsp_tready) begin
               cmd.ann_pop = 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sts.scan_done) state_in = S_ANN;
            else cmd.shift_down = 1'b1;
         end
         S_FIN: begin
            cmd.ann_fin = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("accept while result pending");
   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_kind |=> req_tready)
      else $error("no return to idle after summary");
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.add_step, cmd.shift_up, cmd.shift_down, cmd.ann_pop}))
      else $error("conflicting commands");
`endif
endmodule
`default_nettype wire

// ===== design/delta_list_timeout_queue_core.sv =====
// Top level of the delta-list timer queue: controller plus datapath.
// An announce reports each expired timer before its summary; a stalled result holds the core.
// One item is worked at a time; the next is taken in the cycle after its summary is accepted.
// Reset (synchronous): queue empty, all timers inactive, tick count zero.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timeout_queue_core #(
   parameter int SLOTS = dltq_pkg::SLOTS_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [71:0]  req_tdata,  // operation, timer_id, ticks, forever_req, hw_elapsed
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata,  // expired_id, status, reprogram, hw timeout, current_tick
   output logic         rsp_tuser,  // kind
   output logic         rsp_tlast   // last
);
   dltq_pkg::cmd_type cmd;
   dltq_pkg::sts_type sts;
   logic [3:0]  head_id;
   logic [1:0]  status;
   logic        reprogram, kind;
   logic [30:0] hw_tmo;
   logic [63:0] tick;
   logic [63:0] pop_tick;

   dltq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_kind(kind),
      .cmd(cmd), .sts(sts));

   dltq_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_op(req_tdata[1:0]), .req_id(req_tdata[5:2]), .req_ticks(req_tdata[36:6]),
      .req_forever(req_tdata[37]), .req_hw(req_tdata[68:38]),
      .head_id(head_id), .status(status), .reprogram(reprogram),
      .hw_tmo(hw_tmo), .pop_tick(pop_tick), .tick_ff(tick));

   assign rsp_tuser = kind;
   assign rsp_tlast = kind;
   always_comb begin
      if (kind)
         rsp_tdata = {2'b0, tick, hw_tmo, reprogram, status, 4'd0};
      else
         rsp_tdata = {2'b0, pop_tick, 31'd0, 1'b0, dltq_pkg::ST_OK, head_id};
   end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for delta_list_timeout_queue_core: directed and random timer
// add, abort and announce items against a behavioural delta-list model.
// Depends on dltq_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
   localparam int NSLOT = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [3:0]  xid;
      logic [1:0]  status;
      logic        reprog;
      logic [30:0] next_tmo;
      logic [63:0] tick;
      logic        last;
   } tmr_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   delta_list_timeout_queue_core #(.SLOTS(NSLOT)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow timer list
   logic [31:0] tmr_delta [NSLOT];
   logic        tmr_live  [NSLOT];
   logic [3:0]  tmr_order [NSLOT];
   int          tmr_count;
   logic [63:0] tmr_tick;

   tmr_rsp_type due_q [$];
   int          errors = 0;
   int          n_items = 0;
   int          n_expired = 0;
   int          n_rsp = 0;
   longint      cycles = 0;
   bit          idle_en = 1'b1;
   bit          ds_stall = 1'b0;

   function automatic logic [30:0] head_tmo(logic [30:0] hw);
      longint d;
      if (tmr_count == 0) return dltq_pkg::TMO_MAX;
      d = longint'(tmr_delta[tmr_order[0]]) - longint'(hw);
      if (d > longint'(dltq_pkg::TMO_MAX)) return dltq_pkg::TMO_MAX;
      if (d < 0) return '0;
      return d[30:0];
   endfunction

   function automatic void drop_entry(int pos);
      logic [3:0] id;
      id = tmr_order[pos];
      if (pos + 1 < tmr_count) tmr_delta[tmr_order[pos+1]] += tmr_delta[id];
      for (int i = pos; i + 1 < tmr_count; i++) tmr_order[i] = tmr_order[i+1];
      tmr_count--;
      tmr_live[id] = 1'b0;
   endfunction

   function automatic void predict_timers(logic [1:0] op, logic [3:0] id, logic [30:0] ticks,
                                          logic fvr, logic [30:0] hw);
      tmr_rsp_type r;
      logic [1:0]  st;
      logic        rp;
      logic [31:0] d, rem, dt;
      int          pos;
      logic [3:0]  h;
      st = dltq_pkg::ST_OK;
      rp = 1'b0;
      if (op == dltq_pkg::OP_ADD) begin
         if (fvr) begin
         end else if (tmr_live[id]) begin
            st = dltq_pkg::ST_ACTIVE;
         end else begin
            d = {1'b0, ticks} + 32'd1 + {1'b0, hw};
            pos = tmr_count;
            for (int i = 0; i < tmr_count; i++) begin
               if (tmr_delta[tmr_order[i]] > d) begin
                  tmr_delta[tmr_order[i]] -= d;
                  pos = i;
                  break;
               end
               d -= tmr_delta[tmr_order[i]];
            end
            for (int i = tmr_count; i > pos; i--) tmr_order[i] = tmr_order[i-1];
            tmr_order[pos] = id;
            tmr_delta[id] = d;
            tmr_live[id] = 1'b1;
            tmr_count++;
            rp = (pos == 0);
         end
      end else if (op == dltq_pkg::OP_ABORT) begin
         if (!tmr_live[id]) begin
            st = dltq_pkg::ST_INACTIVE;
         end else begin
            for (int i = 0; i < tmr_count; i++)
               if (tmr_order[i] == id) begin
                  drop_entry(i);
                  break;
               end
         end
      end else if (op == dltq_pkg::OP_ANNOUNCE) begin
         rem = {1'b0, ticks};
         while (tmr_count > 0 && tmr_delta[tmr_order[0]] <= rem) begin
            h = tmr_order[0];
            dt = tmr_delta[h];
            tmr_tick += dt;
            tmr_delta[h] = '0;
            drop_entry(0);
            rem -= dt;
            r = '{kind: 1'b0, xid: h, status: dltq_pkg::ST_OK, reprog: 1'b0, next_tmo: '0,
                  tick: tmr_tick, last: 1'b0};
            due_q.push_back(r);
         end
         if (tmr_count > 0) tmr_delta[tmr_order[0]] -= rem;
         tmr_tick += rem;
         rp = 1'b1;
      end
      r = '{kind: 1'b1, xid: '0, status: st, reprog: rp, next_tmo: head_tmo(hw),
            tick: tmr_tick, last: 1'b1};
      due_q.push_back(r);
   endfunction

   task automatic send_item(logic [1:0] op, logic [3:0] id, logic [30:0] ticks,
                            logic fvr, logic [30:0] hw);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, hw, fvr, ticks, id, op};
      do @(posedge clock); while (!req_tready);
      predict_timers(op, id, ticks, fvr, hw);
      n_items++;
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (4 * NSLOT + 10) @(posedge clock);
   endtask

   // receiver stall bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (idle_en && !ds_stall && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            ds_stall = 1'b1;
            repeat (n) @(posedge clock);
            ds_stall = 1'b0;
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tmr_rsp_type got, want;
      cycles++;
      if (cycles > 2000000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind: rsp_tuser, xid: rsp_tdata[3:0], status: rsp_tdata[5:4],
                 reprog: rsp_tdata[6], next_tmo: rsp_tdata[37:7],
                 tick: rsp_tdata[101:38], last: rsp_tlast};
         n_rsp++;
         if (!got.kind) n_expired++;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %p", got);
         end else begin
            want = due_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("Mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   task automatic test_add_extremes();
      send_item(dltq_pkg::OP_ADD, 4'd0, 31'd0, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ADD, 4'd15, dltq_pkg::TMO_MAX, 1'b0, dltq_pkg::TMO_MAX);
      send_item(dltq_pkg::OP_ADD, 4'd5, 31'd0, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ADD, 4'd0, 31'd7, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ADD, 4'd6, 31'd9, 1'b1, 31'd3);
      send_item(dltq_pkg::OP_ADD, 4'd7, 31'd100, 1'b0, 31'd5);
      send_item(dltq_pkg::OP_ADD, 4'd8, 31'd40, 1'b0, 31'd50);
   endtask

   task automatic test_abort();
      send_item(dltq_pkg::OP_ABORT, 4'd9, 31'd0, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ABORT, 4'd7, 31'd0, 1'b0, 31'd2);
      send_item(dltq_pkg::OP_ABORT, 4'd0, 31'd0, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ABORT, 4'd0, 31'd0, 1'b0, 31'd0);
   endtask

   task automatic test_announce();
      send_item(dltq_pkg::OP_ANNOUNCE, 4'd0, 31'd0, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ANNOUNCE, 4'd0, 31'd95, 1'b0, 31'd1);
      send_item(OP_UNUSED, 4'd3, 31'd5, 1'b1, 31'd5);
      send_item(dltq_pkg::OP_ANNOUNCE, 4'd0, dltq_pkg::TMO_MAX, 1'b0, dltq_pkg::TMO_MAX);
      send_item(dltq_pkg::OP_ANNOUNCE, 4'd0, dltq_pkg::TMO_MAX, 1'b0, 31'd0);
      for (int i = 0; i < NSLOT; i++)
         send_item(dltq_pkg::OP_ADD, i[3:0], 31'd3, 1'b0, 31'd0);
      send_item(dltq_pkg::OP_ANNOUNCE, 4'd0, 31'd10, 1'b0, 31'd0);
   endtask

   task automatic test_random(int count);
      logic [1:0]  op;
      logic [30:0] t;
      for (int k = 0; k < count; k++) begin
         if (k > count * 3 / 4) idle_en = 1'b0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = dltq_pkg::OP_ADD;
            4, 5:       op = dltq_pkg::OP_ABORT;
            6, 7, 8:    op = dltq_pkg::OP_ANNOUNCE;
            default:    op = OP_UNUSED;
         endcase
         case ($urandom_range(0, 5))
            0:       t = 31'($urandom);
            1:       t = 31'(dltq_pkg::TMO_MAX - $urandom_range(0, 3));
            default: t = 31'($urandom_range(0, 200));
         endcase
         send_item(op, 4'($urandom_range(0, 15)), t, $urandom_range(0, 9) == 0,
                   ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20)));
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) tmr_live[i] = 1'b0;
      tmr_count = 0;
      tmr_tick = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_add_extremes();
      test_abort();
      test_announce();
      test_random(140);
      drain_wait();
      $display("Covered %0d items: adds, aborts, announces, ignored and unused codes;",
               n_items);
      $display("%0d results checked, %0d of them expiry reports.", n_rsp, n_expired);
      if (errors == 0 && due_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", errors, due_q.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
